// ===== design/drc_pkg.sv =====
// Shared types and constants for the duplicate request cache.
package drc_pkg;

  localparam int ENTRIES    = 64;
  localparam int IDX_W      = $clog2(ENTRIES);
  localparam int ADDR_BYTES = 32;
  localparam int LEN_W      = 6;
  localparam int XID_W      = 32;
  localparam int LIMIT_W    = 7;
  localparam int KEY_W      = XID_W + LEN_W + 8 * ADDR_BYTES;

  typedef enum logic [1:0] {
    CMD_LOOKUP  = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_ABANDON = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_FREE   = 2'd0,
    ST_NEW    = 2'd1,
    ST_INUSE  = 2'd2,
    ST_REPLAY = 2'd3
  } entry_status_t;

  typedef enum logic [2:0] {
    V_NEW     = 3'd0,
    V_REPLAY  = 3'd1,
    V_PENDING = 3'd2,
    V_FULL    = 3'd3,
    V_DONE    = 3'd4
  } verdict_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_TAKE, S_WALK, S_WALK_RD, S_UNL_WR,
    S_FILL, S_TGT, S_PUSH_TAIL, S_FIN
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_SCAN, OP_HIT, OP_TAKE_FRESH, OP_FULL,
    OP_WALK_START, OP_WALK_STEP, OP_WALK_ADV, OP_CLAIM, OP_UNLINK,
    OP_FILL, OP_RELEASE, OP_ABANDON, OP_PUSH_TAIL, OP_DONE
  } op_t;

  typedef struct packed {
    op_t  op;
    logic in_ready;
    logic emit;
  } drc_cmd_t;

  typedef struct packed {
    logic is_lookup;
    logic is_release;
    logic is_abandon;
    logic hit;
    logic scan_end;
    logic under_limit;
    logic age_empty;
    logic walk_found;
    logic walk_at_head;
    logic target_live;
    logic out_busy;
  } drc_sts_t;

endpackage

// ===== design/drc_if.sv =====
// Request and response channel interfaces.
interface drc_req_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               cmd;
  logic [31:0]              request_xid;
  logic [5:0]               client_addr_len;
  logic [63:0]              client_addr_w0;
  logic [63:0]              client_addr_w1;
  logic [63:0]              client_addr_w2;
  logic [63:0]              client_addr_w3;
  logic [5:0]               target_entry;

  modport source (output valid, cmd, request_xid, client_addr_len, client_addr_w0,
                  client_addr_w1, client_addr_w2, client_addr_w3, target_entry,
                  input ready);
  modport sink (input valid, cmd, request_xid, client_addr_len, client_addr_w0,
                client_addr_w1, client_addr_w2, client_addr_w3, target_entry,
                output ready);
endinterface

interface drc_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] verdict;
  logic [5:0] entry_index;

  modport source (output valid, verdict, entry_index, input ready);
  modport sink (input valid, verdict, entry_index, output ready);
endinterface

// ===== design/drc_ctrl.sv =====
// Sequencer for lookup, age list walk, unlink and relink.
module drc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  drc_pkg::drc_sts_t sts,
  output drc_pkg::drc_cmd_t cmd
);
  import drc_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (!sts.is_lookup) state_next = S_TGT;
        else if (sts.hit) state_next = S_FIN;
        else if (sts.scan_end) state_next = S_TAKE;
      end
      S_TAKE: begin
        if (sts.under_limit) state_next = S_FILL;
        else if (sts.age_empty) state_next = S_FIN;
        else state_next = S_WALK;
      end
      S_WALK: begin
        if (sts.walk_found) state_next = S_UNL_WR;
        else if (sts.walk_at_head) state_next = S_FIN;
        else state_next = S_WALK_RD;
      end
      S_WALK_RD: state_next = S_WALK;
      S_UNL_WR: state_next = sts.is_lookup ? S_FILL : S_PUSH_TAIL;
      S_FILL: state_next = S_FIN;
      S_TGT: begin
        if (sts.target_live && sts.is_abandon) state_next = S_UNL_WR;
        else state_next = S_FIN;
      end
      S_PUSH_TAIL: state_next = S_FIN;
      S_FIN: begin
        if (!sts.out_busy) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '{op: OP_NONE, in_ready: 1'b0, emit: 1'b0};
    unique case (state)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (in_valid) cmd.op = OP_LOAD;
      end
      S_SCAN: begin
        if (sts.is_lookup) cmd.op = sts.hit ? OP_HIT : OP_SCAN;
      end
      S_TAKE: begin
        if (sts.under_limit) cmd.op = OP_TAKE_FRESH;
        else if (sts.age_empty) cmd.op = OP_FULL;
        else cmd.op = OP_WALK_START;
      end
      S_WALK: begin
        if (sts.walk_found) cmd.op = OP_CLAIM;
        else if (sts.walk_at_head) cmd.op = OP_FULL;
        else cmd.op = OP_WALK_STEP;
      end
      S_WALK_RD: cmd.op = OP_WALK_ADV;
      S_UNL_WR: cmd.op = OP_UNLINK;
      S_FILL: cmd.op = OP_FILL;
      S_TGT: begin
        if (sts.target_live && sts.is_release) cmd.op = OP_RELEASE;
        else if (sts.target_live && sts.is_abandon) cmd.op = OP_ABANDON;
        else cmd.op = OP_DONE;
      end
      S_PUSH_TAIL: cmd.op = OP_PUSH_TAIL;
      S_FIN: cmd.emit = !sts.out_busy;
      default: cmd.op = OP_NONE;
    endcase
  end

endmodule

// ===== design/drc_datapath.sv =====
// Entry state, key store, age list links and result register.
module drc_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [drc_pkg::LIMIT_W-1:0]   cfg_wdata,
  input  drc_pkg::drc_cmd_t             cmd,
  output drc_pkg::drc_sts_t             sts,
  drc_req_if.sink                       req,
  drc_rsp_if.source                     rsp
);
  import drc_pkg::*;

  localparam int ABITS = 8 * ADDR_BYTES;

  // configuration and control state
  logic [LIMIT_W-1:0]   entry_limit;
  logic [LIMIT_W-1:0]   alloc_count;
  logic [1:0]           status [ENTRIES];
  logic [ENTRIES-1:0]   linked;
  logic [IDX_W-1:0]     age_head, age_tail;
  logic                 age_empty;
  logic [IDX_W:0]       rd_idx;
  logic                 cmp_v;
  logic [IDX_W-1:0]     cmp_idx;
  logic                 out_valid;

  // payload
  logic [1:0]           cmd_q;
  logic [KEY_W-1:0]     key_q;
  logic [IDX_W-1:0]     cur;
  logic [2:0]           res_verdict;
  logic [IDX_W-1:0]     res_index;
  logic [2:0]           out_verdict;
  logic [IDX_W-1:0]     out_index;

  // memories
  logic [KEY_W-1:0]     key_mem [ENTRIES];
  logic [IDX_W-1:0]     newer_mem [ENTRIES];
  logic [IDX_W-1:0]     older_mem [ENTRIES];
  logic [KEY_W-1:0]     key_rd;
  logic [IDX_W-1:0]     newer_rd, older_rd;

  logic [LEN_W-1:0]     len_c;
  logic [ABITS-1:0]     addr_in, addr_masked;
  logic                 hit;
  logic [LIMIT_W-1:0]   limit_eff;
  logic                 newer_we, older_we;
  logic [IDX_W-1:0]     newer_wa, newer_wd, older_wa, older_wd;
  logic                 link_rd;

  // clamp length and drop bytes past it
  always_comb begin
    len_c = (req.client_addr_len > LEN_W'(ADDR_BYTES)) ? LEN_W'(ADDR_BYTES)
                                                        : req.client_addr_len;
    addr_in = ABITS'({req.client_addr_w3, req.client_addr_w2,
                      req.client_addr_w1, req.client_addr_w0});
    for (int b = 0; b < ADDR_BYTES; b++) begin
      addr_masked[8*b +: 8] = (LEN_W'(b) < len_c) ? addr_in[8*b +: 8] : 8'd0;
    end
  end

  assign limit_eff = (entry_limit > LIMIT_W'(ENTRIES)) ? LIMIT_W'(ENTRIES) : entry_limit;
  assign hit = cmp_v && linked[cmp_idx] && (status[cmp_idx] != ST_FREE) &&
               (key_rd == key_q);

  always_comb begin
    sts.is_lookup    = (cmd_q == CMD_LOOKUP);
    sts.is_release   = (cmd_q == CMD_RELEASE);
    sts.is_abandon   = (cmd_q == CMD_ABANDON);
    sts.hit          = hit;
    sts.scan_end     = cmp_v && (cmp_idx == IDX_W'(ENTRIES - 1));
    sts.under_limit  = alloc_count < limit_eff;
    sts.age_empty    = age_empty;
    sts.walk_found   = (status[cur] == ST_FREE) || (status[cur] == ST_REPLAY);
    sts.walk_at_head = (cur == age_head);
    sts.target_live  = linked[cur] && (status[cur] != ST_FREE);
    sts.out_busy     = out_valid && !rsp.ready;
  end

  // link memory write ports
  always_comb begin
    newer_we = 1'b0; newer_wa = older_rd; newer_wd = newer_rd;
    older_we = 1'b0; older_wa = newer_rd; older_wd = older_rd;
    case (cmd.op)
      OP_UNLINK: begin
        if (age_head != cur && age_tail != cur) begin
          newer_we = 1'b1;
          older_we = 1'b1;
        end
      end
      OP_FILL: begin
        if (!age_empty) begin
          older_we = 1'b1; older_wa = cur;      older_wd = age_head;
          newer_we = 1'b1; newer_wa = age_head; newer_wd = cur;
        end
      end
      OP_PUSH_TAIL: begin
        if (!age_empty) begin
          newer_we = 1'b1; newer_wa = cur;      newer_wd = age_tail;
          older_we = 1'b1; older_wa = age_tail; older_wd = cur;
        end
      end
      default: ;
    endcase
  end

  assign link_rd = (cmd.op == OP_WALK_STEP) || (cmd.op == OP_CLAIM) ||
                   (cmd.op == OP_ABANDON);

  always_ff @(posedge clk) begin
    if (newer_we) newer_mem[newer_wa] <= newer_wd;
    if (older_we) older_mem[older_wa] <= older_wd;
    if (link_rd) begin
      newer_rd <= newer_mem[cur];
      older_rd <= older_mem[cur];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_FILL) key_mem[cur] <= key_q;
    if (cmd.op == OP_SCAN && !rd_idx[IDX_W]) key_rd <= key_mem[rd_idx[IDX_W-1:0]];
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        cmd_q <= req.cmd;
        key_q <= {req.request_xid, len_c, addr_masked};
        cur   <= req.target_entry;
      end
      OP_HIT: begin
        res_verdict <= (status[cmp_idx] == ST_REPLAY) ? V_REPLAY : V_PENDING;
        res_index   <= (status[cmp_idx] == ST_REPLAY) ? cmp_idx : '0;
      end
      OP_TAKE_FRESH: cur <= alloc_count[IDX_W-1:0];
      OP_WALK_START: cur <= age_tail;
      OP_WALK_ADV:   cur <= newer_rd;
      OP_FULL: begin
        res_verdict <= V_FULL;
        res_index   <= '0;
      end
      OP_FILL: begin
        res_verdict <= V_NEW;
        res_index   <= cur;
      end
      OP_RELEASE, OP_DONE, OP_PUSH_TAIL: begin
        res_verdict <= V_DONE;
        res_index   <= '0;
      end
      default: ;
    endcase
    if (cmd.emit) begin
      out_verdict <= res_verdict;
      out_index   <= res_index;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_limit <= LIMIT_W'(64);
      alloc_count <= '0;
      for (int i = 0; i < ENTRIES; i++) status[i] <= ST_FREE;
      linked    <= '0;
      age_head  <= '0;
      age_tail  <= '0;
      age_empty <= 1'b1;
      rd_idx    <= '0;
      cmp_v     <= 1'b0;
      cmp_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) entry_limit <= cfg_wdata;
      if (cmd.emit) out_valid <= 1'b1;
      else if (rsp.ready) out_valid <= 1'b0;
      case (cmd.op)
        OP_LOAD: begin
          rd_idx <= '0;
          cmp_v  <= 1'b0;
        end
        OP_SCAN: begin
          cmp_v   <= !rd_idx[IDX_W];
          cmp_idx <= rd_idx[IDX_W-1:0];
          if (!rd_idx[IDX_W]) rd_idx <= rd_idx + 1'b1;
        end
        OP_HIT: begin
          if (status[cmp_idx] == ST_REPLAY) status[cmp_idx] <= ST_INUSE;
        end
        OP_TAKE_FRESH: alloc_count <= alloc_count + 1'b1;
        OP_CLAIM, OP_ABANDON: status[cur] <= ST_FREE;
        OP_RELEASE: status[cur] <= ST_REPLAY;
        OP_UNLINK: begin
          linked[cur] <= 1'b0;
          if (age_head == cur && age_tail == cur) age_empty <= 1'b1;
          else if (age_head == cur) age_head <= older_rd;
          else if (age_tail == cur) age_tail <= newer_rd;
        end
        OP_FILL: begin
          status[cur] <= ST_NEW;
          linked[cur] <= 1'b1;
          age_head    <= cur;
          if (age_empty) begin
            age_tail  <= cur;
            age_empty <= 1'b0;
          end
        end
        OP_PUSH_TAIL: begin
          linked[cur] <= 1'b1;
          age_tail    <= cur;
          if (age_empty) begin
            age_head  <= cur;
            age_empty <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  assign req.ready       = cmd.in_ready;
  assign rsp.valid       = out_valid;
  assign rsp.verdict     = out_verdict;
  assign rsp.entry_index = out_index;

endmodule

// ===== design/duplicate_request_cache.sv =====
// Duplicate request cache top level: controller plus datapath.
//
// Requests arrive on req (valid/ready); one response per request leaves on
// rsp (valid/ready). cfg_we with cfg_wdata writes entry_limit; write it only
// while the block is idle.
// A lookup reads the key store one entry per cycle. A miss then takes a fresh
// entry, or walks the age list from its tail (S_WALK, then a link memory read
// in S_WALK_RD, per entry) and unlinks the chosen entry; the entry is then
// filled and linked at the head, or the verdict is full. Release, abandon and
// no-op skip the scan; abandon also relinks its target at the age list tail.
// One request is worked on at a time; req.ready is high only when the
// sequencer is idle. The response sits in an output register, so the next
// request is taken while a stalled response waits; a new response waits in
// the sequencer until the output register is free.
// Synchronous reset frees all entries, empties the age list, clears the
// allocation count and sets entry_limit to 64. Keys and links need no reset.
module duplicate_request_cache (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [drc_pkg::LIMIT_W-1:0] cfg_wdata,
  drc_req_if.sink                     req,
  drc_rsp_if.source                   rsp
);
  import drc_pkg::*;

  drc_cmd_t cmd;
  drc_sts_t sts;

  drc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .sts      (sts),
    .cmd      (cmd)
  );

  drc_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .req       (req),
    .rsp       (rsp)
  );

  a_hit_ok: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_HIT |-> sts.hit && sts.is_lookup)
    else $error("hit handled without a matching live entry");

  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> rsp.valid)
    else $error("response not presented after emit");

  a_index_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.verdict != V_NEW && rsp.verdict != V_REPLAY
      |-> rsp.entry_index == '0)
    else $error("nonzero index on a verdict without an entry");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !req.ready)
    else $error("request accepted while a response is being emitted");

endmodule
